/* src/display_reply_frame_parser_assert.svh */
// assertion macros shared by the checker
// each expects clk and arst_n in the scope where it is used
`ifndef DISPLAY_REPLY_FRAME_PARSER_ASSERT_SVH
`define DISPLAY_REPLY_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define DRFP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drfp check failed");

// next-cycle implication
`define DRFP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drfp check failed");

`endif

/* src/drfp_pkg.sv */
package drfp_pkg;

	typedef enum logic [1:0] {
		REQ_BYTE  = 2'd0,
		REQ_START = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		RD_ZERO  = 2'd0,
		RD_FIRST = 2'd1,
		RD_MEM   = 2'd2
	} rd_sel_t;

	// register select is the word address bit of paddr
	localparam logic REG_RAW   = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [6:0] LIMIT_RESET = 7'd80;

	localparam logic [7:0] BYTE_NULL    = 8'h00;
	localparam logic [7:0] BYTE_TERM    = 8'hFF;
	localparam logic [7:0] BYTE_ANS_A4  = 8'hA4;
	localparam logic [7:0] BYTE_ANS_A7  = 8'hA7;
	localparam logic [7:0] BYTE_FD      = 8'hFD;
	localparam logic [7:0] BYTE_FE      = 8'hFE;
	localparam logic [7:0] BYTE_ERR     = 8'h1A;
	localparam logic [7:0] BYTE_TEXT    = 8'h70;
	localparam logic [7:0] BYTE_CONNECT = 8'h63;
	localparam logic [15:0] TERM_PAIR   = 16'hFFFF;

	localparam logic [2:0] RC_NONE    = 3'd0;
	localparam logic [2:0] RC_FD      = 3'd1;
	localparam logic [2:0] RC_FE      = 3'd2;
	localparam logic [2:0] RC_ERR     = 3'd3;
	localparam logic [2:0] RC_TEXT    = 3'd4;
	localparam logic [2:0] RC_CONNECT = 3'd5;

	localparam logic [1:0] AM_NONE = 2'd0;
	localparam logic [1:0] AM_A4   = 2'd1;
	localparam logic [1:0] AM_A7   = 2'd2;

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] count;
		logic [2:0] ready;
		logic       done;
		logic [1:0] answer;
	} result_t;

	typedef struct packed {
		rd_sel_t    sel;
		logic [7:0] first;
	} rd_ctl_t;

	function automatic logic [2:0] classify(input logic [7:0] first, input logic [2:0] cur);
		logic [2:0] code;
		case (first)
			BYTE_FD:      code = RC_FD;
			BYTE_FE:      code = RC_FE;
			BYTE_ERR:     code = RC_ERR;
			BYTE_TEXT:    code = RC_TEXT;
			BYTE_CONNECT: code = RC_CONNECT;
			default:      code = cur;
		endcase
		return code;
	endfunction

endpackage

/* src/display_reply_frame_parser.sv */
// reply frame parser for a serial display link
// input channel (in_valid/in_ready) carries one request item per cycle while in_ready is high:
//   req_type 0 feeds rx_byte, 1 starts a new reception, 2 reads buffer entry
//   read_index, 3 does nothing
// output channel (out_valid/out_ready) gives exactly one result item per request:
//   phase, byte count, ready code, frame done flag, answer mark and read data
// out_valid rises once a request has passed the stage register and then the
// output register; throughput is one item per cycle while out_ready holds, set by the
// single write and single read port of the frame buffer memory
// a stage register and an output register form a two-deep queue, so a new item
// is still taken while a finished result waits; in_ready drops only when both
// hold results and the receiver stalls
// configuration: APB-style, raw_capture_mode at 0x0, frame_limit at 0x4, to be
// written by the user only while the block is idle, which the block does not check; pready is tied high
// reset clears the parser state, the entry zero copy, the pipeline and the
// registers (frame_limit to 80); buffer entries other than zero stay unset
module display_reply_frame_parser #(
	parameter int BUFFER_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  rx_byte,
	input  logic [6:0]  read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  rx_phase,
	output logic [7:0]  byte_count,
	output logic [2:0]  ready_code,
	output logic        frame_done,
	output logic [1:0]  answer_mark,
	output logic [7:0]  read_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import drfp_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);

	// configuration registers
	logic       raw_q;
	logic [6:0] limit_q;
	logic       cfg_wr;

	// request stage and output register
	logic       accept;
	logic       s1_valid_s1;
	result_t    res_s1;
	rd_ctl_t    rdc_s1;
	logic       advance;
	logic       out_valid_q;
	result_t    out_res_q;
	logic [7:0] out_rd_q;
	logic [7:0] rd_pick;

	// buffer connections
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    mem_rd;
	result_t       res_c;
	rd_ctl_t       rdc_c;

	// apb register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q   <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_RAW:   raw_q   <= pwdata[0];
				REG_LIMIT: limit_q <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_RAW:   prdata = {31'b0, raw_q};
			REG_LIMIT: prdata = {25'b0, limit_q};
			default:   prdata = '0;
		endcase
	end

	// stage moves on when the output register is free or being emptied
	assign advance  = s1_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	drfp_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_t'(req_type)),
		.rx_byte    (rx_byte),
		.read_index (read_index),
		.raw_mode   (raw_q),
		.frame_limit(limit_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.result     (res_c),
		.rd_ctl     (rdc_c)
	);

	// read port updates only on accept, so stalled read data holds
	drfp_buf #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_c;
			rdc_s1 <= rdc_c;
		end
	end

	// entry zero comes from its register, out-of-range or non-read gives zero
	always_comb begin
		case (rdc_s1.sel)
			RD_FIRST: rd_pick = rdc_s1.first;
			RD_MEM:   rd_pick = mem_rd;
			default:  rd_pick = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_res_q <= res_s1;
			out_rd_q  <= rd_pick;
		end
	end

	assign out_valid   = out_valid_q;
	assign rx_phase    = out_res_q.phase;
	assign byte_count  = out_res_q.count;
	assign ready_code  = out_res_q.ready;
	assign frame_done  = out_res_q.done;
	assign answer_mark = out_res_q.answer;
	assign read_data   = out_rd_q;

endmodule

/* src/drfp_buf.sv */
module drfp_buf #(
	parameter int BUFFER_DEPTH = 128,
	localparam int AW = $clog2(BUFFER_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [BUFFER_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/drfp_ctrl.sv */
module drfp_ctrl #(
	parameter int BUFFER_DEPTH = 128,
	localparam int AW = $clog2(BUFFER_DEPTH),
	localparam int CW = $clog2(BUFFER_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  drfp_pkg::req_t    req_type,
	input  logic [7:0]        rx_byte,
	input  logic [6:0]        read_index,
	input  logic              raw_mode,
	input  logic [6:0]        frame_limit,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [7:0]        wr_data,
	output logic [AW-1:0]     rd_addr,
	output drfp_pkg::result_t result,
	output drfp_pkg::rd_ctl_t rd_ctl
);

	import drfp_pkg::*;

	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
	localparam logic [AW+6:0] DEPTH_X = (AW + 7)'(BUFFER_DEPTH);

	phase_t        phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic [2:0]    ready_q, ready_d;
	logic [1:0]    answer_q, answer_d;
	logic [15:0]   last2_q, last2_d;
	logic [7:0]    first_q, first_d;

	logic          open_frame;
	logic [CW-1:0] st_base;
	logic [15:0]   st_last_base;
	logic          st_room;
	logic [CW-1:0] st_count;
	logic [7:0]    st_first;
	logic [15:0]   st_last2;
	logic          done;
	logic [AW+6:0] idx_x;
	logic [CW+7:0] count_x;

	// a new frame restarts the fill at entry zero
	assign open_frame   = !raw_mode && (phase_q == PH_IDLE) && (rx_byte != BYTE_NULL);
	assign st_base      = open_frame ? '0 : count_q;
	assign st_last_base = open_frame ? '0 : last2_q;
	assign st_room      = st_base < DEPTH_C;
	assign st_count     = st_room ? st_base + CW'(1) : st_base;
	assign st_first     = (st_room && st_base == '0) ? rx_byte : first_q;
	assign st_last2     = {st_last_base[7:0], rx_byte};
	assign wr_addr      = st_base[AW-1:0];
	assign wr_data      = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			ready_q  <= RC_NONE;
			answer_q <= AM_NONE;
			last2_q  <= '0;
			first_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			ready_q  <= ready_d;
			answer_q <= answer_d;
			last2_q  <= last2_d;
			first_q  <= first_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		ready_d  = ready_q;
		answer_d = answer_q;
		last2_d  = last2_q;
		first_d  = first_q;
		done     = 1'b0;
		wr_en    = 1'b0;
		case (req_type)
			REQ_BYTE: begin
				if (raw_mode) begin
					wr_en   = accept && st_room;
					count_d = st_count;
					last2_d = st_last2;
					first_d = st_first;
				end else begin
					case (phase_q)
						PH_IDLE: begin
							if (open_frame) begin
								wr_en   = accept && st_room;
								count_d = st_count;
								last2_d = st_last2;
								first_d = st_first;
								phase_d = PH_RECV;
								if (rx_byte == BYTE_ANS_A4) begin
									answer_d = AM_A4;
								end
							end
						end
						PH_RECV: begin
							wr_en   = accept && st_room;
							count_d = st_count;
							last2_d = st_last2;
							first_d = st_first;
							if (rx_byte == BYTE_ANS_A7) begin
								if (answer_q == AM_A4) begin
									answer_d = AM_A7;
								end
							end else if (rx_byte == BYTE_TERM) begin
								if (st_count > CW'(3) && last2_q == TERM_PAIR) begin
									phase_d = PH_DONE;
									done    = 1'b1;
									ready_d = classify(st_first, ready_q);
								end
							end else if ((CW + 7)'(st_count) > (CW + 7)'(frame_limit)) begin
								count_d = '0;
								phase_d = PH_IDLE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			REQ_START: begin
				phase_d  = PH_IDLE;
				count_d  = '0;
				ready_d  = RC_NONE;
				answer_d = AM_NONE;
				last2_d  = '0;
				first_d  = '0;
			end
			default: begin
			end
		endcase
	end

	// entry zero is also held in first_q, so reads of it take their data from first_q, not the memory
	assign idx_x   = {{AW{1'b0}}, read_index};
	assign rd_addr = idx_x[AW-1:0];

	always_comb begin
		rd_ctl.first = first_q;
		if (req_type != REQ_READ || idx_x >= DEPTH_X) begin
			rd_ctl.sel = RD_ZERO;
		end else if (read_index == 7'd0) begin
			rd_ctl.sel = RD_FIRST;
		end else begin
			rd_ctl.sel = RD_MEM;
		end
	end

	assign count_x       = {8'b0, count_d};
	assign result.phase  = phase_d;
	assign result.count  = count_x[7:0];
	assign result.ready  = ready_d;
	assign result.done   = done;
	assign result.answer = answer_d;

endmodule

/* src/drfp_checker.sv */
`include "display_reply_frame_parser_assert.svh"

module drfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] rx_phase,
	input logic [7:0] byte_count,
	input logic [2:0] ready_code,
	input logic       frame_done,
	input logic [1:0] answer_mark,
	input logic       pready
);

	import drfp_pkg::*;

	// a closed frame always reports the complete phase
	`DRFP_ASSERT_IMP(a_done_phase, out_valid && frame_done, rx_phase == PH_DONE)
	// codes stay within their defined sets
	`DRFP_ASSERT_IMP(a_codes, out_valid, ready_code <= RC_CONNECT && answer_mark != 2'd3)
	// configuration port never inserts wait states
	`DRFP_ASSERT_IMP(a_pready, 1'b1, pready)
	// a stalled result stays valid and holds its phase, byte count and done flag
	`DRFP_ASSERT_NXT(a_hold, out_valid && !out_ready,
		out_valid && $stable(rx_phase) && $stable(byte_count) && $stable(frame_done))

endmodule

bind display_reply_frame_parser drfp_checker u_drfp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.rx_phase   (rx_phase),
	.byte_count (byte_count),
	.ready_code (ready_code),
	.frame_done (frame_done),
	.answer_mark(answer_mark),
	.pready     (pready)
);
